// ----- rtl/dsa_pkg.sv -----
// Shared constants, command and status codes, and types of the descriptor slot allocator.
// It depends on nothing. The divider and the top level import it.
`default_nettype none

package dsa_pkg;

   localparam int SLOTS     = 1024;
   localparam int FRAMES    = 3;
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;
   localparam int FRAME_W   = 2;
   localparam int ADDR_W    = 48;
   localparam int SIZE_W    = 11;
   localparam int PROD_W    = IDX_W + SIZE_W;
   localparam int DEF_AW    = FRAME_W + IDX_W;
   localparam int STEP_W    = $clog2(IDX_W);
   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 56;
   localparam int RSP_W     = 120;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RECLAIM = 2'd2;
   localparam logic [MODE_W-1:0] MODE_INIT    = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_BAD     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_REFUSED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CPU_BASE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GPU_BASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHADER    = 3'd4;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] quotient;
      logic             exact;
   } dsa_div_res_type;

endpackage

`default_nettype wire

// ----- rtl/dsa_div.sv -----
// Restoring divider that yields a ten-bit quotient, one quotient bit per cycle.
// It depends on dsa_pkg; the caller guarantees the quotient fits.
`default_nettype none

module dsa_div
   import dsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [SIZE_W-1:0] divisor,
   output dsa_div_res_type        res
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0] trial;

   assign trial = PROD_W'(divisor) << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(IDX_W - 1);
         rem_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in          = rem_ff - trial;
            quo_in[step_ff] = 1'b1;
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;
   assign res.exact    = (rem_ff == '0);

endmodule

`default_nettype wire

// ----- rtl/descriptor_slot_allocator_deferred_free_core.sv -----
// Descriptor slot allocator: free stack, live bits and per-frame deferred free lists.
// It depends on dsa_pkg and instantiates dsa_div.
`default_nettype none

// One command is worked on at a time and each gives one response. After reset a clearing
// pass over all 1024 slots writes the identity free stack and clears the live bits; no
// command is taken meanwhile, though register writes are. An allocate reads the stack,
// multiplies and adds; a free runs the ten-step divider and then the live-bit read; a
// reclaim reads each returned slot from the deferred list and writes it onto the free
// stack; an accepted initialize repeats the clearing pass.
// A finished response waits in the output register, and the next command is taken while
// it waits.
module descriptor_slot_allocator_deferred_free_core
   import dsa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,  // handle_address, frame_slot, zero pad
   input  wire logic [MODE_W-1:0]    req_tuser,  // mode
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,  // cpu_address, gpu_address, slot_index,
                                                 // released_count, zero pad
   output logic [STATUS_W-1:0]       rsp_tuser,  // status
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data
);

   localparam logic [3:0] ST_CLEAR      = 4'd0;
   localparam logic [3:0] ST_IDLE       = 4'd1;
   localparam logic [3:0] ST_DECODE     = 4'd2;
   localparam logic [3:0] ST_ALLOC_RD   = 4'd3;
   localparam logic [3:0] ST_ALLOC_ADD  = 4'd4;
   localparam logic [3:0] ST_FREE_RANGE = 4'd5;
   localparam logic [3:0] ST_FREE_DIV   = 4'd6;
   localparam logic [3:0] ST_FREE_LIVE  = 4'd7;
   localparam logic [3:0] ST_RECL_CHK   = 4'd8;
   localparam logic [3:0] ST_RECL_WR    = 4'd9;
   localparam logic [3:0] ST_RESP       = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cap_ff, cap_in;
   logic [SIZE_W-1:0]   dsize_ff, dsize_in;
   logic [ADDR_W-1:0]   cpu_base_ff, cpu_base_in;
   logic [ADDR_W-1:0]   gpu_base_ff, gpu_base_in;
   logic                shvis_ff, shvis_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [CNT_W-1:0]    siu_ff, siu_in;
   logic [CNT_W-1:0]    cnt_ff [FRAMES];
   logic [CNT_W-1:0]    cnt_in [FRAMES];
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic                init_resp_ff, init_resp_in;
   logic [ADDR_W-1:0]   off_ff, off_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [CNT_W-1:0]    walk_ff, walk_in;
   logic [STATUS_W-1:0] r_status_ff, r_status_in;
   logic [ADDR_W-1:0]   r_cpu_ff, r_cpu_in;
   logic [ADDR_W-1:0]   r_gpu_ff, r_gpu_in;
   logic [IDX_W-1:0]    r_slot_ff, r_slot_in;
   logic [CNT_W-1:0]    r_rel_ff, r_rel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0] rsp_user_ff, rsp_user_in;

   logic [IDX_W-1:0]  stack_mem [SLOTS];
   logic [IDX_W-1:0]  stack_rd_ff;
   logic              stack_we;
   logic [IDX_W-1:0]  stack_waddr, stack_wdata, stack_raddr;
   logic              live_mem [SLOTS];
   logic              live_rd_ff;
   logic              live_we, live_wdata;
   logic [IDX_W-1:0]  live_waddr, live_raddr;
   logic [IDX_W-1:0]  def_mem [FRAMES*SLOTS];
   logic [IDX_W-1:0]  def_rd_ff;
   logic              def_we;
   logic [DEF_AW-1:0] def_waddr, def_raddr;

   logic              div_start;
   dsa_div_res_type   div_res;
   logic [CNT_W-1:0]  eff_cap;
   logic              frame_ok;
   logic [CNT_W-1:0]  cnt_sel;
   logic              any_pending;

   assign eff_cap   = (cap_ff > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cap_ff;
   assign frame_ok  = (frame_ff < FRAME_W'(FRAMES));
   assign cnt_sel   = frame_ok ? cnt_ff[frame_ff] : '0;
   assign div_start = (state_ff == ST_FREE_RANGE) &&
                      (off_ff < ADDR_W'({dsize_ff, IDX_W'(0)}));

   always_comb begin
      any_pending = 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
         if (cnt_ff[f] != '0) begin
            any_pending = 1'b1;
         end
      end
   end

   dsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_ff[PROD_W-1:0]),
      .divisor  (dsize_ff),
      .res      (div_res)
   );

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      dsize_in     = dsize_ff;
      cpu_base_in  = cpu_base_ff;
      gpu_base_in  = gpu_base_ff;
      shvis_in     = shvis_ff;
      mode_in      = mode_ff;
      addr_in      = addr_ff;
      frame_in     = frame_ff;
      siu_in       = siu_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      init_resp_in = init_resp_ff;
      off_in       = off_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      walk_in      = walk_ff;
      r_status_in  = r_status_ff;
      r_cpu_in     = r_cpu_ff;
      r_gpu_in     = r_gpu_ff;
      r_slot_in    = r_slot_ff;
      r_rel_in     = r_rel_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      stack_we     = 1'b0;
      stack_waddr  = sweep_ff;
      stack_wdata  = sweep_ff;
      stack_raddr  = siu_ff[IDX_W-1:0];
      live_we      = 1'b0;
      live_wdata   = 1'b0;
      live_waddr   = sweep_ff;
      live_raddr   = div_res.quotient;
      def_we       = 1'b0;
      def_waddr    = {frame_ff, cnt_sel[IDX_W-1:0]};
      def_raddr    = {frame_ff, walk_ff[IDX_W-1:0]};

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY:  cap_in      = csr_data[CNT_W-1:0];
            CSR_DESC_SIZE: dsize_in    = csr_data[SIZE_W-1:0];
            CSR_CPU_BASE:  cpu_base_in = csr_data;
            CSR_GPU_BASE:  gpu_base_in = csr_data;
            CSR_SHADER:    shvis_in    = csr_data[0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            stack_we = 1'b1;
            live_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_W'(SLOTS - 1)) begin
               state_in     = init_resp_ff ? ST_RESP : ST_IDLE;
               init_resp_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in     = req_tuser;
               addr_in     = req_tdata[ADDR_W-1:0];
               frame_in    = req_tdata[ADDR_W +: FRAME_W];
               r_status_in = STAT_OK;
               r_cpu_in    = '0;
               r_gpu_in    = '0;
               r_slot_in   = '0;
               r_rel_in    = '0;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (mode_ff)
               MODE_ALLOC: begin
                  if (siu_ff >= eff_cap) begin
                     r_status_in = STAT_FULL;
                     state_in    = ST_RESP;
                  end else begin
                     state_in = ST_ALLOC_RD;
                  end
               end
               MODE_FREE: begin
                  off_in = addr_ff - cpu_base_ff;
                  if (addr_ff == '0) begin
                     r_status_in = STAT_NULL;
                     state_in    = ST_RESP;
                  end else if (!frame_ok || addr_ff < cpu_base_ff || dsize_ff == '0) begin
                     r_status_in = STAT_BAD;
                     state_in    = ST_RESP;
                  end else begin
                     state_in = ST_FREE_RANGE;
                  end
               end
               MODE_RECLAIM: begin
                  walk_in = '0;
                  if (!frame_ok) begin
                     r_status_in = STAT_BAD;
                     state_in    = ST_RESP;
                  end else begin
                     r_rel_in = cnt_sel;
                     state_in = ST_RECL_CHK;
                  end
               end
               MODE_INIT: begin
                  if (siu_ff != '0 || any_pending) begin
                     r_status_in = STAT_REFUSED;
                     state_in    = ST_RESP;
                  end else begin
                     sweep_in     = '0;
                     init_resp_in = 1'b1;
                     state_in     = ST_CLEAR;
                  end
               end
               default: ;
            endcase
         end
         ST_ALLOC_RD: begin
            idx_in     = stack_rd_ff;
            prod_in    = PROD_W'(stack_rd_ff) * PROD_W'(dsize_ff);
            live_we    = 1'b1;
            live_wdata = 1'b1;
            live_waddr = stack_rd_ff;
            siu_in     = siu_ff + 1'b1;
            state_in   = ST_ALLOC_ADD;
         end
         ST_ALLOC_ADD: begin
            r_cpu_in  = cpu_base_ff + ADDR_W'(prod_ff);
            r_gpu_in  = shvis_ff ? (gpu_base_ff + ADDR_W'(prod_ff)) : '0;
            r_slot_in = idx_ff;
            state_in  = ST_RESP;
         end
         ST_FREE_RANGE: begin
            // Offsets of 1024 strides or more can never name a slot.
            if (div_start) begin
               state_in = ST_FREE_DIV;
            end else begin
               r_status_in = STAT_BAD;
               state_in    = ST_RESP;
            end
         end
         ST_FREE_DIV: begin
            if (div_res.done) begin
               idx_in = div_res.quotient;
               if (!div_res.exact || CNT_W'(div_res.quotient) >= eff_cap) begin
                  r_status_in = STAT_BAD;
                  state_in    = ST_RESP;
               end else begin
                  state_in = ST_FREE_LIVE;
               end
            end
         end
         ST_FREE_LIVE: begin
            if (!live_rd_ff || cnt_sel >= CNT_W'(SLOTS)) begin
               r_status_in = STAT_BAD;
            end else begin
               def_we           = 1'b1;
               cnt_in[frame_ff] = cnt_sel + 1'b1;
               live_we          = 1'b1;
               live_waddr       = idx_ff;
               r_slot_in        = idx_ff;
            end
            state_in = ST_RESP;
         end
         ST_RECL_CHK: begin
            if (walk_ff < cnt_sel && siu_ff != '0) begin
               state_in = ST_RECL_WR;
            end else begin
               cnt_in[frame_ff] = '0;
               state_in         = ST_RESP;
            end
         end
         ST_RECL_WR: begin
            stack_we    = 1'b1;
            stack_waddr = IDX_W'(siu_ff - 1'b1);
            stack_wdata = def_rd_ff;
            siu_in      = siu_ff - 1'b1;
            walk_in     = walk_ff + 1'b1;
            state_in    = ST_RECL_CHK;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = r_status_ff;
               rsp_data_in  = RSP_W'({r_rel_ff, r_slot_ff, r_gpu_ff, r_cpu_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cap_ff       <= CNT_W'(SLOTS);
         dsize_ff     <= SIZE_W'(32);
         cpu_base_ff  <= '0;
         gpu_base_ff  <= '0;
         shvis_ff     <= 1'b0;
         frame_ff     <= '0;
         siu_ff       <= '0;
         for (int f = 0; f < FRAMES; f++) begin
            cnt_ff[f] <= '0;
         end
         sweep_ff     <= '0;
         init_resp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         dsize_ff     <= dsize_in;
         cpu_base_ff  <= cpu_base_in;
         gpu_base_ff  <= gpu_base_in;
         shvis_ff     <= shvis_in;
         frame_ff     <= frame_in;
         siu_ff       <= siu_in;
         cnt_ff       <= cnt_in;
         sweep_ff     <= sweep_in;
         init_resp_ff <= init_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      addr_ff     <= addr_in;
      off_ff      <= off_in;
      idx_ff      <= idx_in;
      prod_ff     <= prod_in;
      walk_ff     <= walk_in;
      r_status_ff <= r_status_in;
      r_cpu_ff    <= r_cpu_in;
      r_gpu_ff    <= r_gpu_in;
      r_slot_ff   <= r_slot_in;
      r_rel_ff    <= r_rel_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
      live_rd_ff <= live_mem[live_raddr];
   end

   always_ff @(posedge clock) begin
      if (def_we) begin
         def_mem[def_waddr] <= idx_ff;
      end
      def_rd_ff <= def_mem[def_raddr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = 1'b1;

   a_siu_bound: assert property (@(posedge clock) disable iff (reset)
      siu_ff <= CNT_W'(SLOTS))
      else $error("slots in use exceed the store size");

   a_recl_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RECL_WR) |-> (siu_ff != '0))
      else $error("reclaim pushes onto a full free stack");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_sel <= CNT_W'(SLOTS))
      else $error("deferred list longer than the store size");

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for descriptor_slot_allocator_deferred_free_core.
// It depends on dsa_pkg and the core. A built-in predictor works out each response.
// A directed table comes first, then random phases with register settings that change.
`timescale 1ns / 1ps

module testbench;
   import dsa_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   cpu;
      logic [ADDR_W-1:0]   gpu;
      logic [IDX_W-1:0]    slot;
      logic [CNT_W-1:0]    released;
   } slot_rsp_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [ADDR_W-1:0]  addr;
      logic [FRAME_W-1:0] frame;
      logic               typed;
      slot_rsp_type       rsp;
   } cmd_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic [MODE_W-1:0]    req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic [STATUS_W-1:0]  rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_data = '0;

   descriptor_slot_allocator_deferred_free_core dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   logic [CNT_W-1:0]  cap_reg;
   logic [SIZE_W-1:0] stride_reg;
   logic [ADDR_W-1:0] cpu_base_reg, gpu_base_reg;
   logic              visible_reg;
   logic [IDX_W-1:0]  stack_mem [SLOTS];
   int unsigned       in_use_cnt;
   logic [IDX_W-1:0]  defer_mem [FRAMES][SLOTS];
   int unsigned       defer_cnt [FRAMES];
   bit                live_bit [SLOTS];
   int                live_q [$];

   slot_rsp_type pending_rsp [$];
   int unsigned  mismatches = 0;
   int unsigned  results_seen = 0;
   int unsigned  burst_left = 0;
   bit           sender_gaps = 1'b1;

   function automatic int unsigned eff_cap();
      return (cap_reg > SLOTS) ? SLOTS : cap_reg;
   endfunction

   function automatic slot_rsp_type allocator_step(logic [MODE_W-1:0] mode,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic [FRAME_W-1:0] frame);
      slot_rsp_type      r;
      logic [ADDR_W-1:0] off;
      logic [ADDR_W-1:0] q;
      int unsigned idx, n, f;
      bit          busy;
      r = '0;
      case (mode)
         MODE_ALLOC: begin
            if (in_use_cnt >= eff_cap()) begin
               r.status = STAT_FULL;
            end else begin
               idx = stack_mem[in_use_cnt];
               off = ADDR_W'(idx * stride_reg);
               r.cpu = cpu_base_reg + off;
               if (visible_reg) r.gpu = gpu_base_reg + off;
               r.slot = IDX_W'(idx);
               in_use_cnt++;
               if (!live_bit[idx]) live_q = {live_q, int'(idx)};
               live_bit[idx] = 1'b1;
            end
         end
         MODE_FREE: begin
            if (addr == 0) begin
               r.status = STAT_NULL;
            end else if (frame >= FRAMES || addr < cpu_base_reg || stride_reg == 0) begin
               r.status = STAT_BAD;
            end else begin
               off = addr - cpu_base_reg;
               q = off / stride_reg;
               if (off % stride_reg != 0 || q >= eff_cap() || !live_bit[q]) begin
                  r.status = STAT_BAD;
               end else if (defer_cnt[frame] >= SLOTS) begin
                  r.status = STAT_BAD;
               end else begin
                  n = defer_cnt[frame];
                  defer_mem[frame][n] = q[IDX_W-1:0];
                  defer_cnt[frame] = n + 1;
                  live_bit[q] = 1'b0;
                  foreach (live_q[i]) if (live_q[i] == q) begin
                     live_q.delete(i);
                     break;
                  end
                  r.slot = q[IDX_W-1:0];
               end
            end
         end
         MODE_RECLAIM: begin
            if (frame >= FRAMES) begin
               r.status = STAT_BAD;
            end else begin
               n = defer_cnt[frame];
               for (int i = 0; i < n; i++) begin
                  if (in_use_cnt == 0) break;
                  in_use_cnt--;
                  stack_mem[in_use_cnt] = defer_mem[frame][i];
               end
               r.released = CNT_W'(n);
               defer_cnt[frame] = 0;
            end
         end
         default: begin
            busy = in_use_cnt != 0;
            for (f = 0; f < FRAMES; f++) if (defer_cnt[f] != 0) busy = 1'b1;
            if (busy) begin
               r.status = STAT_REFUSED;
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  stack_mem[i] = IDX_W'(i);
                  live_bit[i] = 1'b0;
               end
               live_q.delete();
            end
         end
      endcase
      return r;
   endfunction

   task automatic issue_cmd(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                            logic [FRAME_W-1:0] frame, bit typed, slot_rsp_type fixed);
      slot_rsp_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (sender_gaps) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_W-ADDR_W-FRAME_W){1'b0}}, frame, addr};
      do @(posedge clock); while (!req_tready);
      r = allocator_step(mode, addr, frame);
      pending_rsp = {pending_rsp, (typed ? fixed : r)};
   endtask

   task automatic random_cmd();
      int unsigned pick, idx;
      logic [ADDR_W-1:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         issue_cmd(MODE_ALLOC, ADDR_W'({$urandom, $urandom}), FRAME_W'($urandom),
                   1'b0, '0);
      end else if (pick < 75) begin
         if (live_q.size() != 0 && $urandom_range(0, 99) < 80) begin
            idx = live_q[$urandom_range(0, live_q.size() - 1)];
            a = cpu_base_reg + ADDR_W'(idx * stride_reg);
            issue_cmd(MODE_FREE, a, ($urandom_range(0, 19) == 0) ? 2'd3
                      : FRAME_W'($urandom_range(0, 2)), 1'b0, '0);
         end else begin
            case ($urandom_range(0, 3))
               0: a = ADDR_W'({$urandom, $urandom});
               1: a = cpu_base_reg + ADDR_W'($urandom_range(0, 40000));
               2: a = '0;
               default: a = cpu_base_reg - ADDR_W'($urandom_range(1, 64));
            endcase
            issue_cmd(MODE_FREE, a, FRAME_W'($urandom), 1'b0, '0);
         end
      end else if (pick < 93) begin
         issue_cmd(MODE_RECLAIM, ADDR_W'({$urandom, $urandom}),
                   FRAME_W'($urandom_range(0, 3)), 1'b0, '0);
      end else begin
         issue_cmd(MODE_INIT, ADDR_W'({$urandom, $urandom}), FRAME_W'($urandom),
                   1'b0, '0);
      end
   endtask

   // Return every live slot, reclaim all frames and try an initialize.
   task automatic release_all();
      int unsigned idx;
      while (live_q.size() != 0) begin
         idx = live_q[0];
         issue_cmd(MODE_FREE, cpu_base_reg + ADDR_W'(idx * stride_reg),
                   FRAME_W'($urandom_range(0, 2)), 1'b0, '0);
         if (live_q.size() != 0 && live_q[0] == idx) live_q.delete(0);
      end
      for (int f = 0; f < FRAMES; f++) issue_cmd(MODE_RECLAIM, '0, FRAME_W'(f), 1'b0, '0);
      issue_cmd(MODE_INIT, '0, '0, 1'b0, '0);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CAPACITY:  cap_reg = value[CNT_W-1:0];
         CSR_DESC_SIZE: stride_reg = value[SIZE_W-1:0];
         CSR_CPU_BASE:  cpu_base_reg = value;
         CSR_GPU_BASE:  gpu_base_reg = value;
         default:       visible_reg = value[0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [ADDR_W-1:0] pick_base();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return 48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 20000));
         default: return ADDR_W'({$urandom, $urandom});
      endcase
   endfunction

   // Responses are compared at the rising edge on which the transfer happens.
   always @(posedge clock) begin
      slot_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got.status   = rsp_tuser;
         got.cpu      = rsp_tdata[47:0];
         got.gpu      = rsp_tdata[95:48];
         got.slot     = rsp_tdata[105:96];
         got.released = rsp_tdata[116:106];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp st=%0d cpu=%h gpu=%h slot=%0d rel=%0d",
                           want.status, want.cpu, want.gpu, want.slot, want.released);
                  $display("          got st=%0d cpu=%h gpu=%h slot=%0d rel=%0d",
                           got.status, got.cpu, got.gpu, got.slot, got.released);
               end
            end
         end
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off that backs the core up.
   initial begin
      int unsigned style, period;
      bit held;
      held = 1'b0;
      forever begin
         style = $urandom_range(0, 2);
         period = $urandom_range(3, 7);
         for (int c = 0; c < 200; c++) begin
            @(negedge clock);
            if (!held && results_seen >= 300) begin
               held = 1'b1;
               rsp_tready <= 1'b0;
               repeat (400) @(negedge clock);
            end
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 99) < 65);
               default: rsp_tready <= (c % period) != 0;
            endcase
         end
      end
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   cmd_row_type dir_tab [15] = '{
      '{MODE_ALLOC,   48'd0,      2'd0, 1'b1, '{STAT_OK,      48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_ALLOC,   48'd0,      2'd0, 1'b1, '{STAT_OK,      48'd32, 48'd0, 10'd1, 11'd0}},
      '{MODE_FREE,    48'd0,      2'd0, 1'b1, '{STAT_NULL,    48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_FREE,    48'd32,     2'd3, 1'b1, '{STAT_BAD,     48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_FREE,    48'd33,     2'd0, 1'b1, '{STAT_BAD,     48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_FREE,    48'd32736,  2'd0, 1'b1, '{STAT_BAD,     48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_FREE,    '1,         2'd2, 1'b1, '{STAT_BAD,     48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_RECLAIM, '1,         2'd3, 1'b1, '{STAT_BAD,     48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_INIT,    48'd0,      2'd0, 1'b1, '{STAT_REFUSED, 48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_FREE,    48'd32,     2'd1, 1'b1, '{STAT_OK,      48'd0,  48'd0, 10'd1, 11'd0}},
      '{MODE_FREE,    48'd32,     2'd1, 1'b1, '{STAT_BAD,     48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_INIT,    48'd0,      2'd0, 1'b1, '{STAT_REFUSED, 48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_RECLAIM, 48'd0,      2'd1, 1'b1, '{STAT_OK,      48'd0,  48'd0, 10'd0, 11'd1}},
      '{MODE_RECLAIM, 48'd0,      2'd2, 1'b1, '{STAT_OK,      48'd0,  48'd0, 10'd0, 11'd0}},
      '{MODE_ALLOC,   48'd0,      2'd0, 1'b0, '0}
   };

   initial begin
      logic [CNT_W-1:0] caps [6];
      logic [SIZE_W-1:0] sizes [4];
      cap_reg = 1024;
      stride_reg = 32;
      cpu_base_reg = '0;
      gpu_base_reg = '0;
      visible_reg = 1'b0;
      in_use_cnt = 0;
      for (int i = 0; i < SLOTS; i++) begin
         stack_mem[i] = IDX_W'(i);
         live_bit[i] = 1'b0;
      end
      for (int f = 0; f < FRAMES; f++) defer_cnt[f] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         issue_cmd(dir_tab[i].mode, dir_tab[i].addr, dir_tab[i].frame,
                   dir_tab[i].typed, dir_tab[i].rsp);

      for (int ph = 0; ph < 10; ph++) begin
         wait_idle();
         caps = '{11'd1, 11'd2, 11'd1024, 11'd2047, 11'd1500, 11'($urandom_range(1, 1024))};
         sizes = '{11'd1, 11'd1024, 11'd32, 11'($urandom_range(1, 1024))};
         csr_write(CSR_CAPACITY,
                   ADDR_W'((ph < 6) ? caps[ph] : caps[$urandom_range(0, 5)]));
         csr_write(CSR_DESC_SIZE,
                   ADDR_W'((ph < 4) ? sizes[ph] : sizes[$urandom_range(0, 3)]));
         csr_write(CSR_CPU_BASE, (ph == 1) ? '1 : (ph == 2) ? '0 : pick_base());
         csr_write(CSR_GPU_BASE, (ph == 1) ? '1 : (ph == 2) ? '0 : pick_base());
         csr_write(CSR_SHADER, (ph == 0) ? ADDR_W'(0) : (ph == 1) ? ADDR_W'(1)
                   : ADDR_W'($urandom_range(0, 1)));
         sender_gaps = (ph % 3) != 2;
         for (int n = 0; n < 180; n++) random_cmd();
         if (ph % 2 == 1) release_all();
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
